@@ design/wqs_pkg.sv @@
// Shared types and constants for the weighted quantile selector.
`default_nettype none

package wqs_pkg;

  localparam int VALUE_W  = 32;
  localparam int WEIGHT_W = 16;
  localparam int ITEMS_W  = 9;
  localparam int ALPHA_W  = 24;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // Register select bit paddr[2]: register 0 sits at byte address 0.
  localparam logic REG_ALPHA = 1'b0;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_LATCH,
    ST_SCAN,
    ST_JUDGE,
    ST_DONE
  } fsm_state_t;

endpackage

`default_nettype wire

@@ design/wqs_if.sv @@
// Valid/ready channel interfaces for samples and results.
`default_nettype none

interface wqs_sample_if import wqs_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  sample_value;
  logic        [WEIGHT_W-1:0] sample_weight;
  logic                       last_item;

  modport source (output valid, sample_value, sample_weight, last_item, input ready);
  modport sink   (input valid, sample_value, sample_weight, last_item, output ready);
endinterface

interface wqs_result_if import wqs_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] quantile_value;
  logic        [ITEMS_W-1:0] items_seen;
  logic                      overflow;

  modport source (output valid, quantile_value, items_seen, overflow, input ready);
  modport sink   (input valid, quantile_value, items_seen, overflow, output ready);
endinterface

`default_nettype wire

@@ design/wqs_store.sv @@
// Single-port-write, single-port-read sample memory with registered read data.
`default_nettype none

module wqs_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/weighted_quantile_select_top.sv @@
// Weighted alpha-quantile selector: loads (value, weight) sets and returns one quantile per set.
//
// Samples stream in on the sample channel, one transfer per cycle while loading, and are
// written into a single sample memory (value and weight side by side) until a transfer
// with last_item set arrives. The block then evaluates the set of n stored items: for
// each item i it reads item i, then sweeps all n entries through the one read port,
// summing the weights of every item that sorts at or before i (ascending value, ties
// by arrival). If that cumulative weight is <= alpha_threshold the item qualifies; the
// result is the largest qualifying value, or the smallest value of the set if none
// qualifies. The memory read port delivers one entry per cycle during the sweep. The
// result waits in an output register, so loading of the next set can proceed while it
// waits to be taken; only a result still waiting when the next evaluation ends keeps
// the block from loading. Items that arrive when the memory is full are dropped and
// flagged in overflow. No clearing pass is needed: only entries written in the current
// set are read. The user must write alpha_threshold through the APB port at byte
// address 0 only while the block is idle; the block itself does not enforce this.
`default_nettype none

module weighted_quantile_select_top import wqs_pkg::*; #(
  parameter int MAX_ITEMS   = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  wqs_sample_if.sink         sample,
  wqs_result_if.source       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  // Stored weight width: the port carries 16 bits, only the low WEIGHT_BITS of them (at most 16) count.
  localparam int SW    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int CUM_W = SW + CW;
  localparam int CMP_W = (CUM_W > ALPHA_W) ? CUM_W : ALPHA_W;
  localparam int MEM_W = VALUE_W + SW;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  fsm_state_t state, state_next;

  // Load-side state.
  logic [CW-1:0]      fill_count;
  logic               overflow_flag;
  logic [ALPHA_W-1:0] alpha_threshold;

  // Evaluation registers.
  logic [CW-1:0]             i_idx;
  logic [CW-1:0]             j_idx;
  logic [AW-1:0]             jd;
  logic signed [VALUE_W-1:0] vi;
  logic [CUM_W-1:0]          cum;
  logic signed [VALUE_W-1:0] best;
  logic signed [VALUE_W-1:0] lowest;
  logic                      found;

  // Output register.
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic [ITEMS_W-1:0]        out_items;
  logic                      out_ovf;

  // Memory ports.
  logic                      mem_we;
  logic [AW-1:0]             mem_raddr;
  logic [MEM_W-1:0]          mem_rdata;
  logic signed [VALUE_W-1:0] rd_value;
  logic [SW-1:0]             rd_weight;

  logic in_xfer;
  logic out_xfer;
  logic cfg_write;
  logic at_or_before;
  logic cum_ok;
  logic i_last;
  logic scan_done;
  logic out_free;

  assign in_xfer   = sample.valid && sample.ready;
  assign out_xfer  = out_valid && result.ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_free  = !out_valid || result.ready;

  assign rd_value  = mem_rdata[MEM_W-1 -: VALUE_W];
  assign rd_weight = mem_rdata[SW-1:0];

  // Entry jd sorts at or before item i: smaller value, or equal value and no later arrival.
  assign at_or_before = (rd_value < vi) || ((rd_value == vi) && (jd <= i_idx[AW-1:0]));
  assign cum_ok       = CMP_W'(cum) <= CMP_W'(alpha_threshold);
  assign i_last       = (i_idx == fill_count - CW'(1));
  assign scan_done    = (j_idx == fill_count);

  wqs_store #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (MEM_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill_count[AW-1:0]),
    .wdata ({sample.sample_value, sample.sample_weight[SW-1:0]}),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_xfer && sample.last_item) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_LATCH;
      ST_LATCH: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_JUDGE;
        end
      end
      ST_JUDGE: state_next = i_last ? ST_DONE : ST_FETCH;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // State outputs: take samples only while loading; read item i, then sweep j.
  always_comb begin
    sample.ready = 1'b0;
    mem_we       = 1'b0;
    mem_raddr    = j_idx[AW-1:0];
    unique case (state)
      ST_LOAD: begin
        sample.ready = 1'b1;
        mem_we       = sample.valid && (fill_count < MAX_CNT);
      end
      ST_FETCH: mem_raddr = i_idx[AW-1:0];
      ST_LATCH: mem_raddr = '0;
      ST_SCAN,
      ST_JUDGE,
      ST_DONE:  mem_raddr = j_idx[AW-1:0];
      default:  mem_raddr = j_idx[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_LOAD;
      fill_count      <= '0;
      overflow_flag   <= 1'b0;
      alpha_threshold <= '0;
      out_valid       <= 1'b0;
      found           <= 1'b0;
      i_idx           <= '0;
    end else begin
      state <= state_next;

      if (cfg_write && (paddr[2] == REG_ALPHA)) begin
        alpha_threshold <= pwdata[ALPHA_W-1:0];
      end

      // Drop the valid once the result transfers, unless DONE refills it below.
      if (out_xfer && !((state == ST_DONE) && out_free)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (fill_count < MAX_CNT) begin
              fill_count <= fill_count + CW'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
          end
        end
        ST_LATCH: begin
          // Item i arrives now; entry 0 is being read.
          vi    <= rd_value;
          cum   <= '0;
          jd    <= '0;
          j_idx <= CW'(1);
        end
        ST_SCAN: begin
          if (at_or_before) begin
            cum <= cum + CUM_W'(rd_weight);
          end
          if (!scan_done) begin
            jd    <= j_idx[AW-1:0];
            j_idx <= j_idx + CW'(1);
          end
        end
        ST_JUDGE: begin
          if ((i_idx == '0) || (vi < lowest)) begin
            lowest <= vi;
          end
          if (cum_ok) begin
            if (!found || (vi > best)) begin
              best <= vi;
            end
            found <= 1'b1;
          end
          i_idx <= i_last ? '0 : i_idx + CW'(1);
        end
        ST_DONE: begin
          if (out_free) begin
            out_value     <= found ? best : lowest;
            out_items     <= ITEMS_W'({{ITEMS_W{1'b0}}, fill_count});
            out_ovf       <= overflow_flag;
            out_valid     <= 1'b1;
            fill_count    <= '0;
            overflow_flag <= 1'b0;
            found         <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.quantile_value = out_value;
  assign result.items_seen     = out_items;
  assign result.overflow       = out_ovf;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ALPHA) ? APB_DW'(alpha_threshold) : '0;

endmodule

`default_nettype wire

@@ design/wqs_checker.sv @@
// Port-level checks for the weighted quantile selector, bound to the top level.
`default_nettype none

module wqs_port_checker import wqs_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_valid,
  input logic                      s_ready,
  input logic                      s_last,
  input logic                      r_valid,
  input logic                      r_ready,
  input logic signed [VALUE_W-1:0] r_value,
  input logic        [ITEMS_W-1:0] r_items,
  input logic                      r_ovf
);

  // No result is offered right after reset.
  assert property (@(posedge clk) rst |=> !r_valid)
    else $error("result valid after reset");

  // A stalled result holds its valid and payload.
  assert property (@(posedge clk) disable iff (rst)
    (r_valid && !r_ready) |=> (r_valid && $stable(r_value) && $stable(r_items)
                               && $stable(r_ovf)))
    else $error("stalled result changed");

  // The closing sample of a set starts evaluation, so no sample is taken next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_ready && s_last) |=> !s_ready)
    else $error("sample taken during evaluation");

endmodule

bind weighted_quantile_select_top wqs_port_checker u_wqs_checker (
  .clk     (clk),
  .rst     (rst),
  .s_valid (sample.valid),
  .s_ready (sample.ready),
  .s_last  (sample.last_item),
  .r_valid (result.valid),
  .r_ready (result.ready),
  .r_value (result.quantile_value),
  .r_items (result.items_seen),
  .r_ovf   (result.overflow)
);

`default_nettype wire

@@ verif/wqs_checker.sv @@
// Scoreboard for the weighted quantile selector: mirrors the sample sets and checks every result.
`default_nettype none

module wqs_checker import wqs_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic              clk,
  input  logic              rst,
  wqs_sample_if             smp,
  wqs_result_if             res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                mismatches,
  output int                pending,
  output int                sets_done,
  output int                spilled_sets
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_AW-1:0] ALPHA_ADDR = APB_AW'(REG_ALPHA) << 2;
  localparam int SHOW_MAX = 30;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [ITEMS_W-1:0] count;
    logic                      spilled;
  } quantile_t;

  logic        [ALPHA_W-1:0]  alpha;
  // Current set kept in stable ascending order of value.
  logic signed [VALUE_W-1:0]  order_val [CAPACITY];
  logic        [WEIGHT_W-1:0] order_wt  [CAPACITY];
  int                         fill;
  logic                       spill;
  quantile_t                  quantile_q [$];
  int                         miss_ct;
  int                         shown;
  int                         done_ct;
  int                         spill_ct;

  task automatic note_miss(input string what, input logic signed [VALUE_W:0] want,
                           input logic signed [VALUE_W:0] got);
    miss_ct++;
    if (shown < SHOW_MAX) begin
      shown++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    int                p;
    longint unsigned   run;
    quantile_t         want;
    quantile_t         got;
    if (rst) begin
      alpha = '0;
      fill  = 0;
      spill = 1'b0;
      quantile_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ALPHA_ADDR)
        alpha = pwdata[ALPHA_W-1:0];

      if (smp.valid && smp.ready) begin
        if (fill < CAPACITY) begin
          // Insert behind every equal value so ties keep arrival order.
          p = fill;
          while (p > 0 && order_val[p-1] > smp.sample_value) begin
            order_val[p] = order_val[p-1];
            order_wt[p]  = order_wt[p-1];
            p--;
          end
          order_val[p] = smp.sample_value;
          order_wt[p]  = smp.sample_weight;
          fill++;
        end else begin
          spill = 1'b1;
        end
        if (smp.last_item) begin
          // Walk up the sorted set while the running weight stays within alpha.
          run        = 0;
          want.value = order_val[0];
          for (int k = 0; k < fill; k++) begin
            run += order_wt[k];
            if (run > alpha)
              break;
            want.value = order_val[k];
          end
          want.count   = fill[ITEMS_W-1:0];
          want.spilled = spill;
          quantile_q.push_back(want);
          fill  = 0;
          spill = 1'b0;
        end
      end

      if (res.valid && res.ready) begin
        got.value   = res.quantile_value;
        got.count   = res.items_seen;
        got.spilled = res.overflow;
        if (quantile_q.size() == 0) begin
          note_miss("unexpected result: quantile_value", '0, got.value);
        end else begin
          want = quantile_q.pop_front();
          if (got.value !== want.value)
            note_miss("quantile_value", want.value, got.value);
          if (got.count !== want.count)
            note_miss("items_seen", {1'b0, want.count}, {1'b0, got.count});
          if (got.spilled !== want.spilled)
            note_miss("overflow", {1'b0, want.spilled}, {1'b0, got.spilled});
          done_ct++;
          if (want.spilled)
            spill_ct++;
        end
      end
    end
    mismatches   <= miss_ct;
    pending      <= quantile_q.size();
    sets_done    <= done_ct;
    spilled_sets <= spill_ct;
  end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Top of the quantile selector testbench: clock, reset, stimulus, receiver stalls and verdict.
`default_nettype none

module testbench import wqs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 8;
  localparam int CAPACITY    = 256;
  localparam int ITEM_TARGET = 1100;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 12000;
  localparam int SETTLE      = 8;
  localparam int TAIL_CYCLES = 64;
  localparam longint LIMIT_NS = 16_000_000;

  localparam logic [APB_AW-1:0] ALPHA_ADDR = APB_AW'(REG_ALPHA) << 2;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = '1;
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VMAX = ~VMIN;
  localparam logic [WEIGHT_W-1:0] WMAX = '1;

  // How a set draws its values: wide random, a narrow band full of ties, or the extremes.
  typedef enum int {SPREAD_WIDE, SPREAD_TIES, SPREAD_EDGES} spread_e;
  // Receiver behavior for one stretch of cycles.
  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_e;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int mismatches;
  int pending;
  int sets_done;
  int spilled_sets;

  int items_sent   = 0;
  int alpha_writes = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;
  int hold_asked   = 0;
  int hold_served  = 0;

  wqs_sample_if smp ();
  wqs_result_if res ();

  weighted_quantile_select_top #(
    .MAX_ITEMS   (CAPACITY),
    .WEIGHT_BITS (WEIGHT_W)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (smp),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  wqs_checker #(
    .CAPACITY (CAPACITY)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .smp          (smp),
    .res          (res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .sets_done    (sets_done),
    .spilled_sets (spilled_sets)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case the block hangs or stalls forever.
  initial begin
    #(LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  // Receiver: stall on a pattern of its own, switching behavior every stretch. On request,
  // hold off for a long, counted stretch so the block backs up and stalls its input.
  initial begin : receiver
    rx_mode_e mode;
    int       seg_left;
    int       tick;
    seg_left = 0;
    tick     = 0;
    mode     = RX_OPEN;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        res.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++)
          @(posedge clk);
        hold_served++;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(16, 128);
        end
        seg_left--;
        tick++;
        case (mode)
          RX_OPEN:   res.ready <= 1'b1;
          RX_COIN:   res.ready <= 1'($urandom_range(0, 1));
          RX_EVERY4: res.ready <= (tick % 4 == 0);
          default:   res.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Offer one sample and hold it until the transfer; open gaps between bursts.
  task automatic offer(input logic signed [VALUE_W-1:0] v, input logic [WEIGHT_W-1:0] w,
                       input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0 || !gaps_on) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        smp.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    smp.valid         <= 1'b1;
    smp.sample_value  <= v;
    smp.sample_weight <= w;
    smp.last_item     <= last;
    do @(posedge clk); while (!smp.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted quantile has come back.
  task automatic rest_until_drained();
    smp.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write alpha over the register port: setup cycle, then access cycle.
  task automatic set_alpha(input logic [ALPHA_W-1:0] a);
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ALPHA_ADDR;
    pwdata  <= APB_DW'(a);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    alpha_writes++;
  endtask

  function automatic logic signed [VALUE_W-1:0] draw_value(input spread_e s);
    case (s)
      SPREAD_WIDE: return $urandom;
      SPREAD_TIES: return VALUE_W'(int'($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(0, 4))
          0:       return VMIN;
          1:       return VMAX;
          2:       return '0;
          3:       return '1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] draw_weight();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return WEIGHT_W'($urandom_range(0, 65535));
      4, 5:       return WEIGHT_W'($urandom_range(0, 300));
      6:          return '0;
      7:          return WMAX;
      default:    return WEIGHT_W'($urandom_range(7000, 9000));
    endcase
  endfunction

  // Mostly small sets: evaluation cost grows with the square of the set size.
  function automatic int draw_set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return $urandom_range(1, 8);
    else if (r < 90)
      return $urandom_range(9, 24);
    return $urandom_range(25, 64);
  endfunction

  task automatic send_set(input int n);
    spread_e s;
    s = spread_e'($urandom_range(0, 2));
    for (int k = 0; k < n; k++)
      offer(draw_value(s), draw_weight(), k == n - 1);
  endtask

  initial begin : stimulus
    int               phase;
    int               phase_start;
    bit               paused;
    logic [ALPHA_W-1:0] a;

    // Drive every input to a known value from time zero.
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    smp.valid         <= 1'b0;
    smp.sample_value  <= '0;
    smp.sample_weight <= '0;
    smp.last_item     <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sets, alpha at zero: only zero-weight prefixes qualify.
    set_alpha('0);
    offer(VMIN, '0, 1'b1);          // single-item set at the most negative value
    offer(5, 16'd1, 1'b0);          // ties at the low end with zero weight
    offer(-3, '0, 1'b0);
    offer(-3, '0, 1'b1);
    offer(VMAX, WMAX, 1'b0);        // nothing qualifies: fall back to the smallest value
    offer(7, WMAX, 1'b1);
    rest_until_drained();

    // Alpha at its top: every item qualifies, so the largest value wins.
    set_alpha(ALPHA_MAX);
    offer(VMAX, WMAX, 1'b0);
    offer(VMIN, WMAX, 1'b0);
    offer(0, '0, 1'b1);
    offer(-1, WMAX, 1'b0);
    offer(-1, WMAX, 1'b1);
    rest_until_drained();

    // Alpha at one: cumulative weight lands exactly on the threshold.
    set_alpha(ALPHA_W'(65536));
    offer(10, 16'd32768, 1'b0);     // arrival order differs from sorted order
    offer(30, 16'd1, 1'b0);
    offer(20, 16'd32768, 1'b1);
    offer(-1, WMAX, 1'b0);
    offer(-2, 16'd1, 1'b1);
    offer(100, '0, 1'b0);           // equal values split across the threshold
    offer(50, WMAX, 1'b0);
    offer(50, 16'd2, 1'b1);

    // Random phases, each under its own alpha.
    phase  = 0;
    paused = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       a = ALPHA_W'(65536);
        1:       a = ALPHA_W'(32768);
        2:       a = ALPHA_W'($urandom);
        3:       a = '0;
        4:       a = ALPHA_MAX;
        default: a = $urandom_range(0, 1) ? ALPHA_W'($urandom_range(0, 1 << 18))
                                          : ALPHA_W'($urandom);
      endcase
      rest_until_drained();
      set_alpha(a);
      gaps_on = (phase % 3 != 2);
      // Hold the receiver off while the sender keeps offering sets.
      if (phase == 1)
        hold_asked++;
      phase_start = items_sent;
      // One set that fills the store exactly, one that overruns it and loses the items beyond capacity.
      if (phase == 2)
        send_set(CAPACITY);
      if (phase == 5)
        send_set(CAPACITY + $urandom_range(1, 6));
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (phase == 4 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
          rest_until_drained();
          paused = 1'b1;
        end
        send_set(draw_set_size());
      end
      phase++;
    end

    rest_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d quantile sets (%0d with dropped samples) from %0d samples",
             sets_done, spilled_sets, items_sent);
    $display("Alpha was rewritten %0d times, including both ends of its range",
             alpha_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
